/* rtl/dzdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_pkg
// Shared types and constants of the diagonal zone direction classifier.
// ----------------------------------------------------------------------------
package dzdc_pkg;

  localparam int IDX_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 23;
  localparam int DEF_MAX_DIM = 2048;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(12);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(16);

  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS = 1'd0,
    CFG_FRAME_COLS = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_UP    = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_ARG,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    dir_t zone;
    logic last;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_word_t;

  typedef struct packed {
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

/* rtl/dzdc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_in_if
// Mask pixel channel: valid/ready with pixel payload.
// ----------------------------------------------------------------------------
interface dzdc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      pixel_on;
  logic [dzdc_pkg::IDX_W-1:0] row_index;
  logic [dzdc_pkg::IDX_W-1:0] col_index;
  logic                      frame_end;

  modport source (output valid, pixel_on, row_index, col_index, frame_end, input ready);
  modport sink   (input valid, pixel_on, row_index, col_index, frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/dzdc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_out_if
// Result channel: valid/ready with direction and zone counts.
// ----------------------------------------------------------------------------
interface dzdc_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                direction;
  logic [dzdc_pkg::CNT_W-1:0] left_count;
  logic [dzdc_pkg::CNT_W-1:0] up_count;
  logic [dzdc_pkg::CNT_W-1:0] right_count;
  logic [dzdc_pkg::CNT_W-1:0] down_count;

  modport source (output valid, direction, left_count, up_count, right_count, down_count,
                  input ready);
  modport sink   (input valid, direction, left_count, up_count, right_count, down_count,
                  output ready);
endinterface
`default_nettype wire

/* rtl/dzdc_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface dzdc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dzdc_pkg::CFG_IDX_W-1:0] index;
  logic [dzdc_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/dzdc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_front
// Holds the frame size registers, takes pixels and classifies each one into
// a zone by comparing cross products against the diagonal positions.
// ----------------------------------------------------------------------------
module dzdc_front #(
  parameter int MAX_DIM = dzdc_pkg::DEF_MAX_DIM
) (
  input  wire                  clk,
  input  wire                  rst_n,
  dzdc_in_if.sink              in_ch,
  dzdc_cfg_if.sink             cfg_ch,
  input  dzdc_pkg::q_status_t  q_status,
  output dzdc_pkg::q_word_t    q_push
);
  import dzdc_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EXT_W = CFG_W + 1;
  localparam int OPW   = (DIM_W > IDX_W) ? DIM_W : IDX_W;
  localparam int PW    = 2 * OPW;
  localparam int SW    = PW + 1;

  logic [CFG_W-1:0] frame_rows_r;
  logic [CFG_W-1:0] frame_cols_r;
  logic [DIM_W-1:0] eff_rows;
  logic [DIM_W-1:0] eff_cols;
  logic [OPW-1:0]   rows_o;
  logic [OPW-1:0]   cols_o;
  logic [OPW-1:0]   row_o;
  logic [OPW-1:0]   col_o;
  logic             in_frame;
  logic             advance;

  logic             s1_v_r;
  logic             s1_on_r;
  logic             s1_last_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    rc_r;
  logic [PW-1:0]    nc_r;
  logic [OPW-1:0]   c_r;

  logic [SW-1:0]    sum_pr;
  logic [SW-1:0]    sum_nc;
  logic [SW-1:0]    sum_rc;
  logic             gt_d;
  logic             lt_d;
  logic             gt_a;
  logic             lt_a;
  dir_t             zone;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= ROWS_RESET;
      frame_cols_r <= COLS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_FRAME_ROWS: frame_rows_r <= cfg_ch.data;
        CFG_FRAME_COLS: frame_cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign eff_rows = (EXT_W'(frame_rows_r) > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(frame_rows_r);
  assign eff_cols = (EXT_W'(frame_cols_r) > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(frame_cols_r);

  assign rows_o = OPW'(eff_rows);
  assign cols_o = OPW'(eff_cols);
  assign row_o  = OPW'(in_ch.row_index);
  assign col_o  = OPW'(in_ch.col_index);

  assign in_frame = in_ch.pixel_on && (row_o < rows_o) && (col_o < cols_o);

  assign advance     = !s1_v_r || !q_status.full;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_ch.valid) begin
      s1_on_r   <= in_frame;
      s1_last_r <= in_ch.frame_end;
      p_r       <= PW'(rows_o) * PW'(col_o);
      rc_r      <= PW'(row_o) * PW'(cols_o);
      nc_r      <= PW'(rows_o) * PW'(cols_o);
      c_r       <= cols_o;
    end
  end

  // d = floor(rows*col/cols), a = rows - d, all compared as cross products
  assign sum_pr = SW'(p_r) + SW'(rc_r);
  assign sum_nc = SW'(nc_r) + SW'(c_r);
  assign sum_rc = SW'(rc_r) + SW'(c_r);

  assign gt_d = p_r < rc_r;
  assign lt_d = sum_rc <= SW'(p_r);
  assign gt_a = sum_pr >= sum_nc;
  assign lt_a = sum_pr < SW'(nc_r);

  always_comb begin
    zone = DIR_NONE;
    if (s1_on_r) begin
      priority if (gt_d && gt_a) zone = DIR_DOWN;
      else if (lt_d && gt_a)     zone = DIR_RIGHT;
      else if (lt_d && lt_a)     zone = DIR_UP;
      else if (gt_d && lt_a)     zone = DIR_LEFT;
      else                       zone = DIR_NONE;
    end
  end

  assign q_push.valid      = s1_v_r && !q_status.full;
  assign q_push.entry.zone = zone;
  assign q_push.entry.last = s1_last_r;

endmodule
`default_nettype wire

/* rtl/dzdc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module dzdc_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dzdc_pkg::q_word_t    q_push,
  output dzdc_pkg::q_status_t  q_status,
  output dzdc_pkg::q_word_t    q_head,
  input  wire                  q_pop
);
  import dzdc_pkg::*;

  q_entry_t          mem_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r;
  logic [QP_W-1:0]   rd_ptr_r;
  logic [QC_W-1:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign do_push = q_push.valid && (cnt_r != QC_W'(Q_DEPTH));
  assign do_pop  = q_pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QP_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QP_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QC_W'(1);
        2'b01:   cnt_r <= cnt_r - QC_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_push.entry;
  end

  assign q_status.full = (cnt_r == QC_W'(Q_DEPTH));
  assign q_head.valid  = (cnt_r != '0);
  assign q_head.entry  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

/* rtl/dzdc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dzdc_back
// Accumulates zone counts, closes a frame on its last word, resolves the
// direction and holds the result until taken.
// ----------------------------------------------------------------------------
module dzdc_back (
  input  wire                clk,
  input  wire                rst_n,
  input  dzdc_pkg::q_word_t  q_head,
  output logic               q_pop,
  dzdc_out_if.source         out_ch
);
  import dzdc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  back_state_t      state_r;
  back_state_t      state_nxt;

  logic [CNT_W-1:0] left_r,  up_r,  right_r,  down_r;
  logic [CNT_W-1:0] left_nxt, up_nxt, right_nxt, down_nxt;
  logic [CNT_W-1:0] res_left_r, res_up_r, res_right_r, res_down_r;
  dir_t             dir_r;
  dir_t             dir_nxt;
  logic [CNT_W-1:0] best;
  logic             pop;
  logic             pop_last;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      BK_ACC:  pop = q_head.valid;
      BK_ARG:  pop = 1'b0;
      BK_HOLD: pop = q_head.valid && (!q_head.entry.last || out_ch.ready);
      default: pop = 1'b0;
    endcase
  end

  assign q_pop    = pop;
  assign pop_last = pop && q_head.entry.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_ACC:  if (pop_last) state_nxt = BK_ARG;
      BK_ARG:  state_nxt = BK_HOLD;
      BK_HOLD: begin
        if (out_ch.ready) state_nxt = pop_last ? BK_ARG : BK_ACC;
      end
      default: state_nxt = BK_ACC;
    endcase
  end

  always_comb begin
    left_nxt  = left_r;
    up_nxt    = up_r;
    right_nxt = right_r;
    down_nxt  = down_r;
    if (pop) begin
      unique case (q_head.entry.zone)
        DIR_LEFT:  left_nxt  = sat_inc(left_r);
        DIR_UP:    up_nxt    = sat_inc(up_r);
        DIR_RIGHT: right_nxt = sat_inc(right_r);
        DIR_DOWN:  down_nxt  = sat_inc(down_r);
        default: ;
      endcase
    end
  end

  // first of equal counts wins
  always_comb begin
    best    = '0;
    dir_nxt = DIR_NONE;
    if (res_left_r > best) begin
      best    = res_left_r;
      dir_nxt = DIR_LEFT;
    end
    if (res_up_r > best) begin
      best    = res_up_r;
      dir_nxt = DIR_UP;
    end
    if (res_right_r > best) begin
      best    = res_right_r;
      dir_nxt = DIR_RIGHT;
    end
    if (res_down_r > best) begin
      dir_nxt = DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_ACC;
      left_r  <= '0;
      up_r    <= '0;
      right_r <= '0;
      down_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop_last) begin
        left_r  <= '0;
        up_r    <= '0;
        right_r <= '0;
        down_r  <= '0;
      end else begin
        left_r  <= left_nxt;
        up_r    <= up_nxt;
        right_r <= right_nxt;
        down_r  <= down_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      res_left_r  <= left_nxt;
      res_up_r    <= up_nxt;
      res_right_r <= right_nxt;
      res_down_r  <= down_nxt;
    end
    if (state_r == BK_ARG) dir_r <= dir_nxt;
  end

  assign out_ch.valid       = (state_r == BK_HOLD);
  assign out_ch.direction   = dir_r;
  assign out_ch.left_count  = res_left_r;
  assign out_ch.up_count    = res_up_r;
  assign out_ch.right_count = res_right_r;
  assign out_ch.down_count  = res_down_r;

endmodule
`default_nettype wire

/* rtl/diagonal_zone_direction_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_zone_direction_classifier
// Counts set mask pixels in the four diagonal zones of a frame and reports
// the counts and the dominant direction at each frame end.
// Throughput: one pixel per cycle while the queue is not full; a frame end
// pauses the back in its argmax state, which the queue absorbs until it
// fills, then the input stalls. The result is valid once that state ends.
// A frame end that arrives while a result is still held waits in the queue.
// Reset (rst_n low, synchronous) clears counts and queue; size is 12 x 16.
// ----------------------------------------------------------------------------
module diagonal_zone_direction_classifier #(
  parameter int MAX_DIM = dzdc_pkg::DEF_MAX_DIM
) (
  input  wire          clk,
  input  wire          rst_n,
  dzdc_in_if.sink      in_ch,
  dzdc_out_if.source   out_ch,
  dzdc_cfg_if.sink     cfg_ch
);
  import dzdc_pkg::*;

  q_word_t   q_push;
  q_word_t   q_head;
  q_status_t q_status;
  logic      q_pop;

  dzdc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_status (q_status),
    .q_push   (q_push)
  );

  dzdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_status (q_status),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  dzdc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
